[hdl/plu_pkg.sv]
// plu_pkg: shared constants, types and the command word of the property line parser.
// No dependencies; used by every module under hdl.
`default_nettype none

package plu_pkg;

  // Longest name (exclusive) and value (exclusive) in bytes
  localparam int NAME_MAX   = 32;
  localparam int VALUE_MAX  = 128;

  localparam int NAME_DEPTH  = NAME_MAX - 1;
  localparam int NAME_IDX_W  = (NAME_DEPTH > 1) ? $clog2(NAME_DEPTH) : 1;
  localparam int NAME_LEN_W  = $clog2(NAME_MAX);
  localparam int VALUE_CNT_W = $clog2(VALUE_MAX);

  // Command queue between front and back
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

  typedef logic [7:0] byte_t;

  localparam byte_t CH_HASH = 8'h23;
  localparam byte_t CH_EQ   = 8'h3D;
  localparam byte_t CH_LF   = 8'h0A;
  localparam byte_t CH_CR   = 8'h0D;
  localparam byte_t CH_TAB  = 8'h09;
  localparam byte_t CH_SP   = 8'h20;

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_NAME,
    PH_VALUE,
    PH_SKIP
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NAME  = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  // Work for one input byte. Results come out in this order:
  // held CR value byte, value byte, name flush, end marker.
  typedef struct packed {
    logic                  wr0_en;
    logic [NAME_IDX_W-1:0] wr0_idx;
    byte_t                 wr0_data;
    logic                  wr1_en;
    logic [NAME_IDX_W-1:0] wr1_idx;
    byte_t                 wr1_data;
    logic                  val0_en;
    logic                  val1_en;
    byte_t                 val1_data;
    logic [NAME_LEN_W-1:0] flush_len;
    logic                  end_en;
  } cmd_t;

endpackage

`default_nettype wire

[hdl/plu_front.sv]
// plu_front: line state machine; classifies each text byte into a command word.
// Depends on plu_pkg.
`default_nettype none

module plu_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic              q_full,
  input  plu_pkg::byte_t    in_byte,
  input  logic              in_last,
  output plu_pkg::cmd_t     cmd,
  output logic              cmd_push
);

  typedef struct packed {
    plu_pkg::phase_t                  phase;
    logic [plu_pkg::NAME_LEN_W-1:0]   name_count;
    logic [plu_pkg::NAME_LEN_W-1:0]   trim_len;
    logic                             overlong;
    logic [plu_pkg::VALUE_CNT_W-1:0]  value_count;
    logic                             cr_pending;
  } lstate_t;

  typedef struct packed {
    lstate_t                          st;
    logic                             wr_en;
    logic [plu_pkg::NAME_IDX_W-1:0]   wr_idx;
    plu_pkg::byte_t                   wr_data;
    logic                             val_en;
    logic                             flush_en;
  } feed_t;

  lstate_t st;
  lstate_t st_next;
  lstate_t s0;
  lstate_t s1;
  feed_t   f0;
  feed_t   f1;
  logic    end_en;
  logic    accept;

  function automatic logic is_blank(input plu_pkg::byte_t c);
    return (c == plu_pkg::CH_SP) || (c == plu_pkg::CH_TAB);
  endfunction

  // One byte through the line state machine
  function automatic feed_t feed(input lstate_t s, input plu_pkg::byte_t c);
    feed_t r;
    logic  add;
    r          = '0;
    r.st       = s;
    r.wr_data  = c;
    add        = 1'b0;
    unique case (s.phase)
      plu_pkg::PH_LEAD: begin
        if (!is_blank(c)) begin
          if ((c == plu_pkg::CH_HASH) || (c == plu_pkg::CH_EQ)) begin
            r.st.phase = plu_pkg::PH_SKIP;
          end else begin
            r.st.phase      = plu_pkg::PH_NAME;
            r.st.name_count = '0;
            r.st.trim_len   = '0;
            r.st.overlong   = 1'b0;
            add             = 1'b1;
          end
        end
      end
      plu_pkg::PH_NAME: begin
        if (c != plu_pkg::CH_EQ) begin
          add = 1'b1;
        end else if (s.overlong || (s.trim_len == '0)) begin
          r.st.phase = plu_pkg::PH_SKIP;
        end else begin
          r.flush_en       = 1'b1;
          r.st.phase       = plu_pkg::PH_VALUE;
          r.st.value_count = '0;
        end
      end
      plu_pkg::PH_VALUE: begin
        if (s.value_count < plu_pkg::VALUE_CNT_W'(plu_pkg::VALUE_MAX - 1)) begin
          r.val_en         = 1'b1;
          r.st.value_count = s.value_count + 1'b1;
        end
      end
      plu_pkg::PH_SKIP: begin
      end
    endcase
    if (add) begin
      if (r.st.name_count < plu_pkg::NAME_LEN_W'(plu_pkg::NAME_DEPTH)) begin
        r.wr_en         = 1'b1;
        r.wr_idx        = r.st.name_count[plu_pkg::NAME_IDX_W-1:0];
        r.st.name_count = r.st.name_count + 1'b1;
        if (!is_blank(c)) begin
          r.st.trim_len = r.st.name_count;
        end
      end else if (!is_blank(c)) begin
        r.st.overlong = 1'b1;
      end
    end
    return r;
  endfunction

  always_comb begin
    s0     = st;
    f0     = '0;
    f1     = '0;
    cmd    = '0;
    end_en = 1'b0;

    // held CR is an ordinary byte unless LF follows
    if (st.cr_pending) begin
      s0.cr_pending = 1'b0;
      if (in_byte != plu_pkg::CH_LF) begin
        f0            = feed(s0, plu_pkg::CH_CR);
        s0            = f0.st;
        cmd.wr0_en    = f0.wr_en;
        cmd.wr0_idx   = f0.wr_idx;
        cmd.wr0_data  = f0.wr_data;
        cmd.val0_en   = f0.val_en;
      end
    end

    s1 = s0;
    if (in_byte == plu_pkg::CH_LF) begin
      if (s1.phase == plu_pkg::PH_VALUE) begin
        end_en = 1'b1;
      end
      s1.phase = plu_pkg::PH_LEAD;
    end else if ((in_byte == plu_pkg::CH_CR) && (s1.phase != plu_pkg::PH_SKIP)) begin
      s1.cr_pending = 1'b1;
    end else begin
      f1            = feed(s1, in_byte);
      s1            = f1.st;
      cmd.wr1_en    = f1.wr_en;
      cmd.wr1_idx   = f1.wr_idx;
      cmd.wr1_data  = f1.wr_data;
      cmd.val1_en   = f1.val_en;
      cmd.val1_data = in_byte;
      if (f1.flush_en) begin
        cmd.flush_len = f1.st.trim_len;
      end
    end

    st_next = s1;
    if (in_last) begin
      if (st_next.phase == plu_pkg::PH_VALUE) begin
        end_en = 1'b1;
      end
      st_next.phase       = plu_pkg::PH_LEAD;
      st_next.name_count  = '0;
      st_next.trim_len    = '0;
      st_next.overlong    = 1'b0;
      st_next.value_count = '0;
      st_next.cr_pending  = 1'b0;
    end
    cmd.end_en = end_en;

    accept   = push && !q_full;
    cmd_push = accept && (cmd.wr0_en || cmd.wr1_en || cmd.val0_en || cmd.val1_en ||
                          (cmd.flush_len != '0) || cmd.end_en);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase       <= plu_pkg::PH_LEAD;
      st.name_count  <= '0;
      st.trim_len    <= '0;
      st.overlong    <= 1'b0;
      st.value_count <= '0;
      st.cr_pending  <= 1'b0;
    end else if (accept) begin
      st <= st_next;
    end
  end

endmodule

`default_nettype wire

[hdl/plu_cmd_fifo.sv]
// plu_cmd_fifo: short command queue between the front and back parts.
// Depends on plu_pkg (cmd_t, CMDQ_DEPTH).
`default_nettype none

module plu_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  plu_pkg::cmd_t wdata,
  output logic          full,
  input  logic          pop,
  output plu_pkg::cmd_t rdata,
  output logic          empty
);

  plu_pkg::cmd_t                  mem [plu_pkg::CMDQ_DEPTH];
  logic [plu_pkg::CMDQ_PTR_W-1:0] wptr;
  logic [plu_pkg::CMDQ_PTR_W-1:0] rptr;
  logic [plu_pkg::CMDQ_PTR_W:0]   count;

  assign full  = (count == (plu_pkg::CMDQ_PTR_W + 1)'(plu_pkg::CMDQ_DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/plu_back.sv]
// plu_back: name store and result sequencer; one result per cycle into the output register while the receiver keeps up.
// Depends on plu_pkg.
`default_nettype none

module plu_back (
  input  logic          clk,
  input  logic          rst,
  input  plu_pkg::cmd_t q_head,
  input  logic          q_empty,
  output logic          q_pop,
  input  logic          pop,
  output logic          empty,
  output logic [1:0]    out_kind,
  output logic [7:0]    out_byte,
  output logic          out_last
);

  plu_pkg::byte_t                 name_store [plu_pkg::NAME_DEPTH];

  logic                           cur_valid;
  logic                           cur_val0;
  logic                           cur_val1;
  plu_pkg::byte_t                 cur_val1_data;
  logic [plu_pkg::NAME_LEN_W-1:0] cur_flush_len;
  logic                           cur_end;
  logic [plu_pkg::NAME_LEN_W-1:0] fidx;
  logic [plu_pkg::NAME_LEN_W-1:0] fidx_inc;

  logic                           out_valid;
  plu_pkg::kind_t                 out_kind_r;
  plu_pkg::byte_t                 out_byte_r;
  logic                           out_last_r;

  logic                           flush_left;
  logic                           rem;
  plu_pkg::kind_t                 sel_kind;
  plu_pkg::byte_t                 sel_byte;
  logic                           out_take;
  logic                           advance;
  logic                           done;
  logic                           head_has;

  always_comb begin
    flush_left = (fidx != cur_flush_len);
    fidx_inc   = fidx + 1'b1;
    priority if (cur_val0) begin
      sel_kind = plu_pkg::KIND_VALUE;
      sel_byte = plu_pkg::CH_CR;
      rem      = cur_val1 || flush_left || cur_end;
    end else if (cur_val1) begin
      sel_kind = plu_pkg::KIND_VALUE;
      sel_byte = cur_val1_data;
      rem      = flush_left || cur_end;
    end else if (flush_left) begin
      sel_kind = plu_pkg::KIND_NAME;
      sel_byte = name_store[fidx[plu_pkg::NAME_IDX_W-1:0]];
      rem      = (fidx_inc != cur_flush_len) || cur_end;
    end else begin
      sel_kind = plu_pkg::KIND_END;
      sel_byte = '0;
      rem      = 1'b0;
    end
    out_take = !out_valid || pop;
    advance  = cur_valid && out_take;
    done     = advance && !rem;
    q_pop    = !q_empty && (!cur_valid || done);
    head_has = q_head.val0_en || q_head.val1_en || (q_head.flush_len != '0) ||
               q_head.end_en;
  end

  // name bytes land when their command is loaded, ahead of any flush that reads them
  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (q_head.wr0_en) begin
        name_store[q_head.wr0_idx] <= q_head.wr0_data;
      end
      if (q_head.wr1_en) begin
        name_store[q_head.wr1_idx] <= q_head.wr1_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_valid <= head_has;
      end else if (done) begin
        cur_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_val0      <= q_head.val0_en;
      cur_val1      <= q_head.val1_en;
      cur_val1_data <= q_head.val1_data;
      cur_flush_len <= q_head.flush_len;
      cur_end       <= q_head.end_en;
      fidx          <= '0;
    end else if (advance) begin
      priority if (cur_val0) begin
        cur_val0 <= 1'b0;
      end else if (cur_val1) begin
        cur_val1 <= 1'b0;
      end else if (flush_left) begin
        fidx <= fidx_inc;
      end else begin
        cur_end <= 1'b0;
      end
    end
    if (advance) begin
      out_kind_r <= sel_kind;
      out_byte_r <= sel_byte;
      out_last_r <= !rem;
    end
  end

  assign empty    = !out_valid;
  assign out_kind = out_kind_r;
  assign out_byte = out_byte_r;
  assign out_last = out_last_r;

  // a live command always has something left to emit
  a_cur_pending: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (cur_val0 || cur_val1 || flush_left || cur_end))
    else $error("back holds a command with nothing left");

  // a name flush never shares a byte with value output
  a_flush_excl: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !((q_head.flush_len != '0) && (q_head.val0_en || q_head.val1_en)))
    else $error("flush mixed with value bytes");

  // flush reads stay inside the name store
  a_flush_range: assert property (@(posedge clk) disable iff (rst)
    (advance && !cur_val0 && !cur_val1 && flush_left) |->
      (fidx < plu_pkg::NAME_LEN_W'(plu_pkg::NAME_DEPTH)))
    else $error("flush index beyond name store");

endmodule

`default_nettype wire

[hdl/property_line_parser_unit.sv]
// property_line_parser_unit: top level of the property line parser.
// Depends on plu_pkg, plu_front, plu_cmd_fifo, plu_back.
//
// Usage:
//  Input queue side: drive in_byte/in_last and raise push; a transfer happens
//  on a rising edge with push high and full low. in_last marks the final byte
//  of a text and closes any open line.
//  Result queue side: while empty is low, out_kind/out_byte/out_last show the
//  oldest result (name byte, value byte or end of property marker); a transfer
//  happens on a rising edge with pop high and empty low. out_last flags the
//  final result caused by one input byte.
//  Results pass the command queue, the back part's current-command register and
//  the output register after the transfer of the byte that causes them. The back
//  part emits one result per cycle while the receiver keeps up; '=' releases every
//  buffered name byte (up to 31), and a held CR or a closing end marker adds one more result.
//  The 4-entry command queue absorbs these bursts; full rises once it fills.
//  Reset (rst, synchronous) empties the queue and output register and returns
//  the line state to leading whitespace. The name store is not cleared.
//  When the receiver stalls, the output register holds its result, the back
//  part stops, and the queue fills until full stops input transfers.
`default_nettype none

module property_line_parser_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic       out_last
);

  // command word from the classifier into the queue
  plu_pkg::cmd_t cmd_in;
  plu_pkg::cmd_t cmd_head;
  logic          cmd_push;
  logic          cmd_pop;
  logic          q_full;
  logic          q_empty;

  // front: line state, whitespace/comment/name handling
  plu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .q_full   (q_full),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .cmd      (cmd_in),
    .cmd_push (cmd_push)
  );

  // decoupling queue; its full flag is the input backpressure
  plu_cmd_fifo u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (q_full),
    .pop   (cmd_pop),
    .rdata (cmd_head),
    .empty (q_empty)
  );

  // back: name buffer and result sequencing
  plu_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_head   (cmd_head),
    .q_empty  (q_empty),
    .q_pop    (cmd_pop),
    .pop      (pop),
    .empty    (empty),
    .out_kind (out_kind),
    .out_byte (out_byte),
    .out_last (out_last)
  );

  assign full = q_full;

endmodule

`default_nettype wire

[tb/plu_checker.sv]
// plu_checker: watches both queue sides of property_line_parser_unit, predicts
// the result stream of every accepted text byte and compares each popped result.
// Depends on plu_pkg for the byte and kind types and the character constants.
`timescale 1ns / 1ps

module plu_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       empty,
  input  logic       pop,
  input  logic [1:0] out_kind,
  input  logic [7:0] out_byte,
  input  logic       out_last,
  output int         mismatches,
  output int         outstanding,
  output int         results_seen,
  output int         props_closed
);
  import plu_pkg::*;

  localparam int MAX_PER_BYTE = 32;

  typedef struct packed {
    kind_t kind;
    byte_t data;
    logic  last;
  } prop_result_t;

  prop_result_t expected_q[$];
  prop_result_t burst_q[$];

  // Line parser state
  phase_t line_st;
  byte_t  name_buf [NAME_MAX-1];
  int     name_len;
  int     trim_len;
  int     val_len;
  bit     name_too_long;
  bit     cr_held;

  initial begin
    mismatches   = 0;
    outstanding  = 0;
    results_seen = 0;
    props_closed = 0;
  end

  function automatic bit is_blank(byte_t c);
    return c == CH_SP || c == CH_TAB;
  endfunction

  task automatic add_result(kind_t k, byte_t d);
    prop_result_t r;
    if (burst_q.size() < MAX_PER_BYTE) begin
      r.kind = k;
      r.data = d;
      r.last = 1'b0;
      burst_q.push_back(r);
    end
  endtask

  // Bytes past the store are dropped; a non-blank one spoils the name
  task automatic store_name_char(byte_t c);
    if (name_len < NAME_MAX - 1) begin
      name_buf[name_len] = c;
      name_len++;
      if (!is_blank(c))
        trim_len = name_len;
    end else if (!is_blank(c)) begin
      name_too_long = 1'b1;
    end
  endtask

  task automatic parse_char(byte_t c);
    case (line_st)
      PH_LEAD: begin
        if (!is_blank(c)) begin
          if (c == CH_HASH || c == CH_EQ) begin
            line_st = PH_SKIP;
          end else begin
            line_st       = PH_NAME;
            name_len      = 0;
            trim_len      = 0;
            name_too_long = 1'b0;
            store_name_char(c);
          end
        end
      end
      PH_NAME: begin
        if (c != CH_EQ) begin
          store_name_char(c);
        end else if (name_too_long || trim_len == 0) begin
          line_st = PH_SKIP;
        end else begin
          for (int i = 0; i < trim_len; i++)
            add_result(KIND_NAME, name_buf[i]);
          line_st = PH_VALUE;
          val_len = 0;
        end
      end
      PH_VALUE: begin
        if (val_len < VALUE_MAX - 1) begin
          add_result(KIND_VALUE, c);
          val_len++;
        end
      end
      default: ;
    endcase
  endtask

  task automatic close_line();
    if (line_st == PH_VALUE)
      add_result(KIND_END, 8'h00);
    line_st = PH_LEAD;
  endtask

  task automatic predict_byte(byte_t b, logic last);
    burst_q.delete();
    // held CR: dropped before LF, otherwise an ordinary byte
    if (cr_held) begin
      cr_held = 1'b0;
      if (b != CH_LF)
        parse_char(CH_CR);
    end
    if (b == CH_LF)
      close_line();
    else if (b == CH_CR && line_st != PH_SKIP)
      cr_held = 1'b1;
    else
      parse_char(b);
    if (last) begin
      close_line();
      name_len      = 0;
      trim_len      = 0;
      name_too_long = 1'b0;
      val_len       = 0;
      cr_held       = 1'b0;
    end
    if (burst_q.size() > 0)
      burst_q[burst_q.size()-1].last = 1'b1;
    foreach (burst_q[i])
      expected_q.push_back(burst_q[i]);
  endtask

  task automatic check_result();
    prop_result_t want;
    results_seen++;
    if (expected_q.size() == 0) begin
      if (mismatches < 10)
        $display("%0t: unexpected result kind=%0d byte=%02h last=%0b",
                 $realtime, out_kind, out_byte, out_last);
      mismatches++;
    end else begin
      want = expected_q.pop_front();
      if (out_kind !== want.kind || out_byte !== want.data || out_last !== want.last) begin
        if (mismatches < 10)
          $display("%0t: mismatch exp kind=%0d byte=%02h last=%0b, got kind=%0d byte=%02h last=%0b",
                   $realtime, want.kind, want.data, want.last, out_kind, out_byte, out_last);
        mismatches++;
      end
      if (want.kind == KIND_END)
        props_closed++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      line_st       = PH_LEAD;
      name_len      = 0;
      trim_len      = 0;
      val_len       = 0;
      name_too_long = 1'b0;
      cr_held       = 1'b0;
    end else begin
      if (push && !full)
        predict_byte(in_byte, in_last);
      if (pop && !empty)
        check_result();
    end
    outstanding = expected_q.size();
  end

endmodule

[tb/property_line_parser_unit_test.sv]
// property_line_parser_unit_test: drives property text into property_line_parser_unit
// under several idle/stall mixes and a long receiver hold; plu_checker judges results.
// Depends on plu_pkg, plu_checker and the RTL under hdl.
`timescale 1ns / 1ps

module property_line_parser_unit_test;
  import plu_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int HOLD_CYCLES  = 150;     // long receiver hold-off, fills the block
  localparam int CYCLE_LIMIT  = 400000;  // far above the slowest legal run
  localparam int PHASE_BYTES  = 45;      // minimum property-line bytes per idle/stall mix
  localparam int DRAIN_CYCLES = 16;

  logic       clk = 1'b0;
  logic       rst;
  logic       push;
  logic       full;
  logic [7:0] in_byte;
  logic       in_last;
  logic       empty;
  logic       pop;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic       out_last;

  int mismatches;
  int outstanding;
  int results_seen;
  int props_closed;

  // Knobs: written only by the stimulus process
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_pending = 0;
  // Written only by the receiver process
  int hold_served  = 0;

  int bytes_sent = 0;
  int prop_bytes = 0;
  int cycles     = 0;

  always #(CLK_HALF) clk = ~clk;

  property_line_parser_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .empty    (empty),
    .pop      (pop),
    .out_kind (out_kind),
    .out_byte (out_byte),
    .out_last (out_last)
  );

  plu_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .in_byte      (in_byte),
    .in_last      (in_last),
    .empty        (empty),
    .pop          (pop),
    .out_kind     (out_kind),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .results_seen (results_seen),
    .props_closed (props_closed)
  );

  // Watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles, outstanding);
      $display("property_line_parser_unit_test: FAIL");
      $finish;
    end
  end

  // Receiver: random stalls per rx_stall_pct; on request a long hold-off,
  // counted here, while the sender keeps offering bytes.
  initial begin
    pop = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_served != hold_pending) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_served++;
      end
      pop <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // One transfer. Called at a rising edge; returns at the edge that took the byte.
  // push stays high between back-to-back bytes, so no low/high pair in one step.
  task automatic send_byte(byte_t b, logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_byte <= b;
    in_last <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_seq(byte_t seq[$], logic last_at_end);
    foreach (seq[i])
      send_byte(seq[i], last_at_end && (i == seq.size() - 1));
  endtask

  task automatic send_text(string s, logic last_at_end);
    byte_t seq[$];
    for (int i = 0; i < s.len(); i++)
      seq.push_back(byte_t'(s[i]));
    send_seq(seq, last_at_end);
  endtask

  function automatic byte_t letter();
    return byte_t'($urandom_range(8'h7A, 8'h61));
  endfunction

  function automatic byte_t blank();
    return ($urandom_range(1) == 0) ? CH_SP : CH_TAB;
  endfunction

  // Name bytes: mostly letters, some blanks, some arbitrary bytes (CR included)
  function automatic byte_t name_char();
    byte_t c;
    case ($urandom_range(9))
      0, 1: begin
        do c = byte_t'($urandom_range(255));
        while (c == CH_EQ || c == CH_LF);
      end
      2:       c = CH_SP;
      default: c = letter();
    endcase
    return c;
  endfunction

  // Value bytes: anything but LF; '=', '#' and CR are legal content
  function automatic byte_t value_char();
    byte_t c;
    case ($urandom_range(9))
      0, 1, 2: begin
        do c = byte_t'($urandom_range(255));
        while (c == CH_LF);
      end
      3:       c = CH_SP;
      default: c = byte_t'($urandom_range(8'h7E, 8'h21));
    endcase
    return c;
  endfunction

  // Well-formed "name = value" line with random content. Names sometimes sit
  // around the store limit, values now and then run past the cut-off.
  task automatic send_property_line();
    byte_t seq[$];
    int    n_name;
    int    n_trail;
    int    n_val;
    logic  at_end;
    repeat ($urandom_range(2)) seq.push_back(blank());
    n_name = ($urandom_range(5) == 0) ? $urandom_range(34, 29) : $urandom_range(6, 1);
    seq.push_back(letter());
    repeat (n_name - 1) seq.push_back(name_char());
    n_trail = ($urandom_range(9) == 0) ? $urandom_range(5, 3) : $urandom_range(2);
    repeat (n_trail) seq.push_back(blank());
    seq.push_back(CH_EQ);
    n_val = ($urandom_range(29) == 0) ? $urandom_range(132, 125) : $urandom_range(8);
    repeat (n_val) seq.push_back(value_char());
    at_end = 1'b0;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: seq.push_back(CH_LF);
      5, 6: begin
        seq.push_back(CH_CR);
        seq.push_back(CH_LF);
      end
      7, 8: at_end = 1'b1;           // end of text on the last byte ('=' if no value)
      default: begin
        seq.push_back(CH_CR);        // held CR on the final byte
        at_end = 1'b1;
      end
    endcase
    prop_bytes += seq.size();
    send_seq(seq, at_end);
  endtask

  // Lines that yield nothing, plus raw noise
  task automatic send_other_line();
    byte_t seq[$];
    logic  at_end;
    at_end = 1'b0;
    case ($urandom_range(4))
      0: begin                       // comment, CR inside is not held
        repeat ($urandom_range(1)) seq.push_back(blank());
        seq.push_back(CH_HASH);
        repeat ($urandom_range(5)) seq.push_back(value_char());
        seq.push_back(CH_LF);
      end
      1: begin                       // empty or blank-only line
        repeat ($urandom_range(2)) seq.push_back(blank());
        if ($urandom_range(1) == 0) seq.push_back(CH_CR);
        seq.push_back(CH_LF);
      end
      2: begin                       // no '=': dropped, or cut by end of text
        seq.push_back(letter());
        repeat ($urandom_range(4)) seq.push_back(name_char());
        if ($urandom_range(3) == 0) at_end = 1'b1;
        else seq.push_back(CH_LF);
      end
      3: begin                       // empty name
        repeat ($urandom_range(2)) seq.push_back(blank());
        seq.push_back(CH_EQ);
        repeat ($urandom_range(3)) seq.push_back(value_char());
        seq.push_back(CH_LF);
      end
      default: begin                 // noise
        repeat ($urandom_range(6, 1)) seq.push_back(byte_t'($urandom_range(255)));
        at_end = ($urandom_range(7) == 0);
      end
    endcase
    send_seq(seq, at_end);
  endtask

  initial begin
    rst     = 1'b1;
    push    = 1'b0;
    in_byte = 8'h00;
    in_last = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: byte extremes, CR before LF, comment, empty name,
    // line without '=', trimmed name with held CR then text end,
    // CR opening a name. CR is written as octal 015.
    send_text("a=", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("\015\n", 1'b0);
    send_text("#\n", 1'b0);
    send_text("\t=\n", 1'b0);
    send_text("k\n", 1'b0);
    send_text("b \t=\015z\015", 1'b1);
    send_text("\015k=v", 1'b1);

    // Random: no idling (with the long receiver hold), sender idle,
    // receiver stalling, both lightly.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
          hold_pending++;
        end
        1: begin
          tx_idle_pct  = 74;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 74;
        end
        default: begin
          tx_idle_pct  = 14;
          rx_stall_pct = 14;
        end
      endcase
      prop_bytes = 0;
      while (prop_bytes < PHASE_BYTES) begin
        if ($urandom_range(99) < 70) send_property_line();
        else send_other_line();
      end
    end

    push <= 1'b0;
    rx_stall_pct = 0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d text bytes across four idle/stall mixes and one long hold-off;",
             bytes_sent);
    $display("%0d results checked, %0d properties closed, %0d mismatches, %0d missing.",
             results_seen, props_closed, mismatches, outstanding);
    if (mismatches == 0 && outstanding == 0)
      $display("property_line_parser_unit_test: PASS");
    else
      $display("property_line_parser_unit_test: FAIL");
    $finish;
  end

endmodule
